/* hdl/cdiv_pkg.sv */
// Shared types and constants for the complex divider.
package cdiv_pkg;

	// Default magnitude width of one operand part (ports carry one more bit for sign)
	localparam int OPERAND_WIDTH_DEF = 17;

	// Width of one quotient part and its saturation bound
	localparam int QUOT_W = 25;
	localparam logic [QUOT_W-1:0] QUOT_LIMIT = 25'd14142200;

	// Control that travels alongside each request
	typedef struct packed {
		logic valid;
		logic zero;
		logic neg_re;
		logic neg_im;
		logic sat_re;
		logic sat_im;
	} cdiv_ctl_t;

endpackage

/* hdl/cdiv_front.sv */
// Front end: cross products, numerator and denominator sums, scaling by 100.
module cdiv_front #(
	parameter int W  = cdiv_pkg::OPERAND_WIDTH_DEF + 1,
	parameter int XW = 2 * W + 26
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] num_real,
	input  logic signed [W-1:0] num_imag,
	input  logic signed [W-1:0] den_real,
	input  logic signed [W-1:0] den_imag,
	output logic [XW-1:0]       rem_re_s3,
	output logic [XW-1:0]       rem_im_s3,
	output logic [XW-1:0]       den_s3,
	output cdiv_pkg::cdiv_ctl_t ctl_s3
);

	logic signed [2*W-1:0] ac_s1, bd_s1, bc_s1, ad_s1, cc_s1, dd_s1;
	cdiv_pkg::cdiv_ctl_t   ctl_s1, ctl_s2;
	cdiv_pkg::cdiv_ctl_t   ctl_new, ctl_sgn;
	logic signed [2*W:0]   nre_s2, nim_s2;
	logic [2*W-1:0]        den_s2;
	logic [2*W:0]          mag_re, mag_im;
	logic [XW-1:0]         ext_re, ext_im;

	always_ff @(posedge clk) begin
		ac_s1 <= num_real * den_real;
		bd_s1 <= num_imag * den_imag;
		bc_s1 <= num_imag * den_real;
		ad_s1 <= num_real * den_imag;
		cc_s1 <= den_real * den_real;
		dd_s1 <= den_imag * den_imag;
		nre_s2 <= $signed({ac_s1[2*W-1], ac_s1}) + $signed({bd_s1[2*W-1], bd_s1});
		nim_s2 <= $signed({bc_s1[2*W-1], bc_s1}) - $signed({ad_s1[2*W-1], ad_s1});
		den_s2 <= $unsigned(cc_s1) + $unsigned(dd_s1);
		// scale by 100 = 64 + 32 + 4
		rem_re_s3 <= (ext_re << 6) + (ext_re << 5) + (ext_re << 2);
		rem_im_s3 <= (ext_im << 6) + (ext_im << 5) + (ext_im << 2);
		den_s3 <= {{(XW-2*W){1'b0}}, den_s2};
	end

	always_comb begin
		mag_re = nre_s2[2*W] ? $unsigned(-nre_s2) : $unsigned(nre_s2);
		mag_im = nim_s2[2*W] ? $unsigned(-nim_s2) : $unsigned(nim_s2);
		ext_re = {{(XW-2*W-1){1'b0}}, mag_re};
		ext_im = {{(XW-2*W-1){1'b0}}, mag_im};
	end

	always_comb begin
		ctl_new       = '0;
		ctl_new.valid = start;
		ctl_new.zero  = (den_real == '0) && (den_imag == '0);
		ctl_sgn        = ctl_s2;
		ctl_sgn.neg_re = nre_s2[2*W];
		ctl_sgn.neg_im = nim_s2[2*W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_new;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_sgn;
		end
	end

endmodule

/* hdl/cdiv_div_stage.sv */
// One restoring-division step: retire one quotient bit for both parts.
module cdiv_div_stage #(
	parameter int XW    = 2 * (cdiv_pkg::OPERAND_WIDTH_DEF + 1) + 26,
	parameter int SHIFT = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [XW-1:0]             rem_re_in,
	input  logic [XW-1:0]             rem_im_in,
	input  logic [XW-1:0]             den_in,
	input  logic [cdiv_pkg::QUOT_W-1:0] q_re_in,
	input  logic [cdiv_pkg::QUOT_W-1:0] q_im_in,
	input  cdiv_pkg::cdiv_ctl_t       ctl_in,
	output logic [XW-1:0]             rem_re_out,
	output logic [XW-1:0]             rem_im_out,
	output logic [XW-1:0]             den_out,
	output logic [cdiv_pkg::QUOT_W-1:0] q_re_out,
	output logic [cdiv_pkg::QUOT_W-1:0] q_im_out,
	output cdiv_pkg::cdiv_ctl_t       ctl_out
);

	logic [XW-1:0] dsh;
	logic          ge_re, ge_im;
	logic [cdiv_pkg::QUOT_W-1:0] q_re_nx, q_im_nx;

	always_comb begin
		dsh   = den_in << SHIFT;
		ge_re = rem_re_in >= dsh;
		ge_im = rem_im_in >= dsh;
		q_re_nx = q_re_in;
		q_im_nx = q_im_in;
		q_re_nx[SHIFT] = ge_re;
		q_im_nx[SHIFT] = ge_im;
	end

	always_ff @(posedge clk) begin
		rem_re_out <= ge_re ? rem_re_in - dsh : rem_re_in;
		rem_im_out <= ge_im ? rem_im_in - dsh : rem_im_in;
		den_out    <= den_in;
		q_re_out   <= q_re_nx;
		q_im_out   <= q_im_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

endmodule

/* hdl/complex_divider_top.sv */
// A request taken at a clock edge shows its result, with done high, at the end of the pipeline.
// Throughput: one request every cycle; busy stays low, as every stage advances each cycle.
// The depth comes from 3 front stages, 1 overflow check, 25 one-bit division steps, 1 output.
// Reset clears the valid bits of all stages and done; data registers are not reset.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module complex_divider_top #(
	parameter int OPERAND_WIDTH = cdiv_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [OPERAND_WIDTH:0]       num_real,
	input  logic signed [OPERAND_WIDTH:0]       num_imag,
	input  logic signed [OPERAND_WIDTH:0]       den_real,
	input  logic signed [OPERAND_WIDTH:0]       den_imag,
	output logic                                done,
	output logic signed [cdiv_pkg::QUOT_W-1:0]  quot_real_x100,
	output logic signed [cdiv_pkg::QUOT_W-1:0]  quot_imag_x100,
	output logic                                div_by_zero
);

	localparam int W  = OPERAND_WIDTH + 1;
	localparam int QW = cdiv_pkg::QUOT_W;
	// room for |numerator|*100 and for the denominator shifted by QW
	localparam int XW = 2 * W + QW + 1;

	logic [XW-1:0]       rem_re_s3, rem_im_s3, den_s3;
	cdiv_pkg::cdiv_ctl_t ctl_s3, ctl_s4;
	cdiv_pkg::cdiv_ctl_t ctl_chk;
	logic [XW-1:0]       rem_re_s4, rem_im_s4, den_s4;
	logic [XW-1:0]       den_top;

	logic [XW-1:0]       rem_re [0:QW];
	logic [XW-1:0]       rem_im [0:QW];
	logic [XW-1:0]       den_p  [0:QW];
	logic [QW-1:0]       q_re   [0:QW];
	logic [QW-1:0]       q_im   [0:QW];
	cdiv_pkg::cdiv_ctl_t ctl_p  [0:QW];

	logic [QW-1:0]       mag_re, mag_im;
	cdiv_pkg::cdiv_ctl_t ctl_end;

	// never hold off a request
	assign busy = 1'b0;

	cdiv_front #(.W(W), .XW(XW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.num_real  (num_real),
		.num_imag  (num_imag),
		.den_real  (den_real),
		.den_imag  (den_imag),
		.rem_re_s3 (rem_re_s3),
		.rem_im_s3 (rem_im_s3),
		.den_s3    (den_s3),
		.ctl_s3    (ctl_s3)
	);

	// Overflow check: a scaled quotient of 2^QW or more saturates regardless of its low bits
	assign den_top = den_s3 << QW;

	always_comb begin
		ctl_chk        = ctl_s3;
		ctl_chk.sat_re = rem_re_s3 >= den_top;
		ctl_chk.sat_im = rem_im_s3 >= den_top;
	end

	always_ff @(posedge clk) begin
		rem_re_s4 <= rem_re_s3;
		rem_im_s4 <= rem_im_s3;
		den_s4    <= den_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4 <= ctl_chk;
		end
	end

	assign rem_re[0] = rem_re_s4;
	assign rem_im[0] = rem_im_s4;
	assign den_p[0]  = den_s4;
	assign q_re[0]   = '0;
	assign q_im[0]   = '0;
	assign ctl_p[0]  = ctl_s4;

	// One quotient bit per stage, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_div
		cdiv_div_stage #(.XW(XW), .SHIFT(QW - 1 - k)) u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.rem_re_in  (rem_re[k]),
			.rem_im_in  (rem_im[k]),
			.den_in     (den_p[k]),
			.q_re_in    (q_re[k]),
			.q_im_in    (q_im[k]),
			.ctl_in     (ctl_p[k]),
			.rem_re_out (rem_re[k+1]),
			.rem_im_out (rem_im[k+1]),
			.den_out    (den_p[k+1]),
			.q_re_out   (q_re[k+1]),
			.q_im_out   (q_im[k+1]),
			.ctl_out    (ctl_p[k+1])
		);
	end

	// Clamp magnitudes, then restore sign; a zero divisor forces both parts to zero
	assign ctl_end = ctl_p[QW];

	always_comb begin
		mag_re = (ctl_end.sat_re || (q_re[QW] > cdiv_pkg::QUOT_LIMIT)) ?
			cdiv_pkg::QUOT_LIMIT : q_re[QW];
		mag_im = (ctl_end.sat_im || (q_im[QW] > cdiv_pkg::QUOT_LIMIT)) ?
			cdiv_pkg::QUOT_LIMIT : q_im[QW];
	end

	always_ff @(posedge clk) begin
		if (ctl_end.zero) begin
			quot_real_x100 <= '0;
			quot_imag_x100 <= '0;
		end else begin
			quot_real_x100 <= ctl_end.neg_re ? $signed(-mag_re) : $signed(mag_re);
			quot_imag_x100 <= ctl_end.neg_im ? $signed(-mag_im) : $signed(mag_im);
		end
		div_by_zero <= ctl_end.zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_end.valid;
		end
	end

endmodule
